// File: src/rtte_pkg.sv
package rtte_pkg;

    localparam int FRAC_BITS = 5;
    localparam int SAMPLE_W  = 20;
    localparam int RTT_W     = SAMPLE_W + FRAC_BITS;
    localparam int TO_W      = RTT_W + 3;
    localparam int CNT_W     = 5;
    localparam int SECS_W    = 12;
    localparam int CLAMP_MS_W = 18;

    // seconds rounding: x = (t + 500 ms) >> (FRAC_BITS + 3), then x / 125
    localparam int SEC_X_W     = TO_W + 1 - FRAC_BITS - 3;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_125 = 22'd2147484;
    localparam int PROD_W      = SEC_X_W + RECIP_W;

    localparam logic [RTT_W-1:0]  VAR_INIT     = RTT_W'(750 << FRAC_BITS);
    localparam logic [TO_W-1:0]   TO_INIT      = TO_W'(3000 << FRAC_BITS);
    localparam logic [TO_W:0]     HALF_SEC_Q   = (TO_W + 1)'(500 << FRAC_BITS);
    localparam logic [CNT_W-1:0]  RETRY_MAX    = 5'd16;
    localparam logic [SECS_W-1:0] SECS_SAT     = '1;

    localparam logic [1:0] ACT_NEW     = 2'd0;
    localparam logic [1:0] ACT_SAMPLE  = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    localparam logic [1:0] REG_MIN_TO = 2'd0;
    localparam logic [1:0] REG_MAX_TO = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    localparam logic [7:0] MIN_TO_RST = 8'd2;
    localparam logic [7:0] MAX_TO_RST = 8'd60;
    localparam logic [3:0] LIMIT_RST  = 4'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [SAMPLE_W-1:0] sample_ms;
    } in_item_t;

    typedef struct packed {
        logic [SECS_W-1:0] timeout_s;
        logic              give_up;
        logic [CNT_W-1:0]  retries;
    } out_item_t;

    typedef struct packed {
        logic [7:0] min_timeout_s;
        logic [7:0] max_timeout_s;
        logic [3:0] retransmit_limit;
    } cfg_t;

    typedef struct packed {
        logic [TO_W-1:0]  timeout_q;
        logic             give_up;
        logic [CNT_W-1:0] retries;
    } est_res_t;

endpackage

// File: src/rtte_cfg_regs.sv
module rtte_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [1:0]    wr_index,
    input  logic [7:0]    wr_data,
    output rtte_pkg::cfg_t cfg
);
    import rtte_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_MIN_TO: cfg_next.min_timeout_s    = wr_data;
                REG_MAX_TO: cfg_next.max_timeout_s    = wr_data;
                REG_LIMIT:  cfg_next.retransmit_limit = wr_data[3:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_timeout_s    <= MIN_TO_RST;
            cfg_reg.max_timeout_s    <= MAX_TO_RST;
            cfg_reg.retransmit_limit <= LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/rtte_estimator.sv
module rtte_estimator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               upd,
    input  rtte_pkg::in_item_t item,
    input  rtte_pkg::cfg_t     cfg,
    output rtte_pkg::est_res_t res
);
    import rtte_pkg::*;

    logic [RTT_W-1:0] srtt_reg, srtt_next;
    logic [RTT_W-1:0] var_reg, var_next;
    logic [TO_W-1:0]  to_reg, to_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             give_up;

    logic [CLAMP_MS_W-1:0] lo_ms, hi_ms;
    logic [TO_W-1:0]       lo_q, hi_q;

    logic [RTT_W-1:0]        s_q;
    logic signed [RTT_W+1:0] delta, delta_neg, diff, srtt_sum, var_sum;
    logic [RTT_W-1:0]        mag, srtt_smp, var_smp;
    logic [TO_W-1:0]         to_raw, to_smp, to_dbl, to_init;
    logic [CNT_W-1:0]        cnt_inc;

    function automatic logic [TO_W-1:0] clamp_to(
        input logic [TO_W-1:0] t,
        input logic [TO_W-1:0] lo,
        input logic [TO_W-1:0] hi
    );
        logic [TO_W-1:0] r;
        begin
            if (t < lo)
                r = lo;
            else if (t > hi)
                r = hi;
            else
                r = t;
            return r;
        end
    endfunction

    always_comb
    begin
        lo_ms = CLAMP_MS_W'(cfg.min_timeout_s) * CLAMP_MS_W'(1000);
        hi_ms = CLAMP_MS_W'(cfg.max_timeout_s) * CLAMP_MS_W'(1000);
        lo_q  = TO_W'(lo_ms) << FRAC_BITS;
        hi_q  = TO_W'(hi_ms) << FRAC_BITS;

        // sample update; arithmetic shifts give the floor for negative deltas
        s_q       = {item.sample_ms, {FRAC_BITS{1'b0}}};
        delta     = $signed({2'b00, s_q}) - $signed({2'b00, srtt_reg});
        delta_neg = -delta;
        mag       = delta[RTT_W] ? delta_neg[RTT_W-1:0] : delta[RTT_W-1:0];
        srtt_sum  = $signed({2'b00, srtt_reg}) + (delta >>> 3);
        diff      = $signed({2'b00, mag}) - $signed({2'b00, var_reg});
        var_sum   = $signed({2'b00, var_reg}) + (diff >>> 2);
        srtt_smp  = srtt_sum[RTT_W-1:0];
        var_smp   = var_sum[RTT_W-1:0];
        to_raw    = {3'b000, srtt_smp} + {1'b0, var_smp, 2'b00};
        to_smp    = clamp_to(to_raw, lo_q, hi_q);

        to_dbl  = to_reg[TO_W-1] ? {TO_W{1'b1}} : {to_reg[TO_W-2:0], 1'b0};
        to_init = clamp_to(TO_INIT, lo_q, hi_q);
        cnt_inc = (cnt_reg < RETRY_MAX) ? cnt_reg + 1'b1 : cnt_reg;
    end

    always_comb
    begin
        srtt_next = srtt_reg;
        var_next  = var_reg;
        to_next   = to_reg;
        cnt_next  = cnt_reg;
        give_up   = 1'b0;
        case (item.action)
            ACT_NEW:
            begin
                cnt_next = '0;
            end
            ACT_SAMPLE:
            begin
                srtt_next = srtt_smp;
                var_next  = var_smp;
                to_next   = to_smp;
            end
            ACT_TIMEOUT:
            begin
                cnt_next = cnt_inc;
                if (cnt_inc > {1'b0, cfg.retransmit_limit})
                begin
                    give_up   = 1'b1;
                    srtt_next = '0;
                    var_next  = VAR_INIT;
                    to_next   = to_init;
                end
                else
                begin
                    to_next = to_dbl;
                end
            end
            default:
            begin
                give_up = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srtt_reg <= '0;
            var_reg  <= VAR_INIT;
            to_reg   <= TO_INIT;
            cnt_reg  <= '0;
        end
        else if (upd)
        begin
            srtt_reg <= srtt_next;
            var_reg  <= var_next;
            to_reg   <= to_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign res.timeout_q = to_next;
    assign res.give_up   = give_up;
    assign res.retries   = cnt_next;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= RETRY_MAX)
        else $error("retry count beyond saturation");

    a_giveup_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        upd && give_up |=> srtt_reg == '0 && var_reg == VAR_INIT)
        else $error("estimator not reinitialized on give-up");

    a_new_clears: assert property (@(posedge clk) disable iff (!rst_n)
        upd && item.action == ACT_NEW |=> cnt_reg == '0)
        else $error("new packet did not clear retry count");

endmodule

// File: src/rtte_sec_round.sv
module rtte_sec_round (
    input  logic [rtte_pkg::TO_W-1:0]   timeout_q,
    output logic [rtte_pkg::SECS_W-1:0] timeout_s
);
    import rtte_pkg::*;

    logic [TO_W:0]    x_full;
    logic [SEC_X_W-1:0] x;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-RECIP_SHIFT-1:0] q;

    // divide by 1000 ms in Q: shift out 8*2^F, then multiply by 1/125
    always_comb
    begin
        x_full = {1'b0, timeout_q} + HALF_SEC_Q;
        x      = x_full[TO_W:FRAC_BITS+3];
        prod   = PROD_W'(x) * PROD_W'(RECIP_125);
        q      = prod[PROD_W-1:RECIP_SHIFT];
        if (q > (PROD_W-RECIP_SHIFT)'(SECS_SAT))
            timeout_s = SECS_SAT;
        else
            timeout_s = q[SECS_W-1:0];
    end

endmodule

// File: src/rtt_retransmit_timeout_estimator.sv
// A request waits in the input register until it advances; its result is then registered.
// Throughput: one request per cycle unless a stalled result holds it; the estimator update and
// seconds rounding sit in one register-to-register path between the input and result registers.
// Reset (rst_n, async, active low): no pending request, srtt 0, deviation 750 ms,
// timeout 3000 ms, retry count 0, limits min 2 s, max 60 s, retransmit limit 3.
module rtt_retransmit_timeout_estimator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rtte_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rtte_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import rtte_pkg::*;

    logic      in_vld_reg, in_vld_next;
    in_item_t  in_item_reg;
    logic      out_vld_reg, out_vld_next;
    out_item_t out_item_reg;
    logic      advance;
    logic      accept;
    cfg_t      cfg;
    est_res_t  res;
    logic [SECS_W-1:0] secs;

    assign cfg_ready = 1'b1;

    rtte_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rtte_estimator u_est (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    rtte_sec_round u_round (
        .timeout_q (res.timeout_q),
        .timeout_s (secs)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;

        if (advance)
            out_vld_next = 1'b1;
        else if (!out_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_data;
        if (advance)
        begin
            out_item_reg.timeout_s <= secs;
            out_item_reg.give_up   <= res.give_up;
            out_item_reg.retries   <= res.retries;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_item_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg && out_stall)
        else $error("input stalled without a blocked result");

    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("processed request produced no result");

    a_giveup_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.give_up |-> out_data.retries != '0)
        else $error("give-up reported with zero retries");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import rtte_pkg::*;

    localparam logic [1:0]      ACT_UNUSED = 2'd3;
    localparam logic [1:0]      REG_NONE   = 2'd3;
    localparam logic [TO_W-1:0] TO_SAT     = '1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // estimator state as the block should hold it
    logic [7:0]       lim_min;
    logic [7:0]       lim_max;
    logic [3:0]       lim_retx;
    logic [RTT_W-1:0] est_srtt;
    logic [RTT_W-1:0] est_dev;
    logic [TO_W-1:0]  est_to;
    logic [CNT_W-1:0] est_retries;

    out_item_t rto_reports_due[$];

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_span;
    int hold_left;
    bit hold_taken;
    int mismatches;
    int events_sent;
    int reports_checked;
    int give_ups_seen;

    rtt_retransmit_timeout_estimator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("tb_top: run timed out with %0d results still due", rto_reports_due.size());
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic [TO_W-1:0] clamp_rto(input longint t);
        longint lo;
        longint hi;
        lo = (longint'(lim_min) * 1000) << FRAC_BITS;
        hi = (longint'(lim_max) * 1000) << FRAC_BITS;
        // min test wins when the range is inverted
        if (t < lo)
            return TO_W'(lo);
        if (t > hi)
            return TO_W'(hi);
        return TO_W'(t);
    endfunction

    function automatic void reset_estimator();
        est_srtt = '0;
        est_dev  = VAR_INIT;
        est_to   = clamp_rto(4 * longint'(VAR_INIT));
    endfunction

    function automatic out_item_t next_rto_report(input in_item_t ev);
        longint    sq;
        longint    srtt;
        longint    dev;
        longint    delta;
        longint    mag;
        longint    secs;
        out_item_t rep;
        rep = '0;
        case (ev.action)
            ACT_NEW:
                est_retries = '0;
            ACT_SAMPLE:
            begin
                sq    = longint'(ev.sample_ms) << FRAC_BITS;
                srtt  = longint'(est_srtt);
                dev   = longint'(est_dev);
                delta = sq - srtt;
                mag   = (delta < 0) ? -delta : delta;
                srtt  = srtt + (delta >>> 3);
                dev   = dev + ((mag - dev) >>> 2);
                est_srtt = RTT_W'(srtt);
                est_dev  = RTT_W'(dev);
                est_to   = clamp_rto(srtt + 4 * dev);
            end
            ACT_TIMEOUT:
            begin
                est_to = (est_to > TO_SAT / 2) ? TO_SAT : est_to << 1;
                if (est_retries < RETRY_MAX)
                    est_retries = est_retries + 1'b1;
                if (est_retries > CNT_W'(lim_retx))
                begin
                    rep.give_up = 1'b1;
                    reset_estimator();
                end
            end
            default: ;
        endcase
        secs = (longint'(est_to) + (longint'(500) << FRAC_BITS)) / (longint'(1000) << FRAC_BITS);
        rep.timeout_s = (secs > 4095) ? SECS_SAT : SECS_W'(secs);
        rep.retries   = est_retries;
        return rep;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample_ms();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? '1 : '0;
            1, 2, 3: return SAMPLE_W'($urandom_range(3000));
            4, 5, 6: return SAMPLE_W'($urandom_range(300000));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic in_item_t make_event(input logic [1:0] act, input logic [SAMPLE_W-1:0] ms);
        in_item_t ev;
        ev.action    = act;
        ev.sample_ms = ms;
        return ev;
    endfunction

    // a result is taken at an edge where out_valid is high and out_stall low
    task automatic check_report(input out_item_t got);
        out_item_t want;
        if (rto_reports_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb_top: result with nothing due: timeout_s %0d give_up %0d retries %0d",
                         got.timeout_s, got.give_up, got.retries);
            return;
        end
        want = rto_reports_due.pop_front();
        reports_checked++;
        if (got.give_up)
            give_ups_seen++;
        if (got.timeout_s !== want.timeout_s || got.give_up !== want.give_up ||
            got.retries !== want.retries)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"tb_top: result %0d: timeout_s %0d/%0d give_up %0d/%0d ",
                          "retries %0d/%0d (exp/got)"},
                         reports_checked, want.timeout_s, got.timeout_s, want.give_up,
                         got.give_up, want.retries, got.retries);
        end
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_report(out_data);
            if (hold_span != 0 && !hold_taken)
            begin
                hold_left  = hold_span;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // in_valid is left high on return; the next request or wait_drained follows
    task automatic send_event(input in_item_t ev);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rto_reports_due.push_back(next_rto_report(ev));
        events_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (rto_reports_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_TO: lim_min  = val;
            REG_MAX_TO: lim_max  = val;
            REG_LIMIT:  lim_retx = val[3:0];
            default: ;
        endcase
    endtask

    task automatic test_event_basics();
        send_event(make_event(ACT_NEW, '0));
        send_event(make_event(ACT_UNUSED, '1));
        send_event(make_event(ACT_SAMPLE, '0));
        send_event(make_event(ACT_SAMPLE, '1));
        send_event(make_event(ACT_SAMPLE, 20'd100));
        // default limit 3: fourth expiry gives up, fifth keeps giving up
        repeat (5)
            send_event(make_event(ACT_TIMEOUT, 20'h5A5A5));
        send_event(make_event(ACT_NEW, 20'hA5A5A));
    endtask

    task automatic test_clamp_limits();
        write_reg(REG_MIN_TO, 8'd1);
        write_reg(REG_MAX_TO, 8'd255);
        write_reg(REG_LIMIT, 8'd15);
        send_event(make_event(ACT_NEW, '0));
        send_event(make_event(ACT_SAMPLE, '1));
        // doubling and seconds saturate, then count pins at 16
        repeat (17)
            send_event(make_event(ACT_TIMEOUT, '0));
        write_reg(REG_MIN_TO, 8'd200);
        write_reg(REG_MAX_TO, 8'd5);
        write_reg(REG_NONE, 8'hFF);
        send_event(make_event(ACT_SAMPLE, 20'd10));
        send_event(make_event(ACT_SAMPLE, '1));
    endtask

    task automatic run_phase(input logic [7:0] mn, input logic [7:0] mx, input logic [3:0] lim,
                             input int tx_pct, input int rx_pct, input int n);
        in_item_t seq[$];
        int       left;
        write_reg(REG_MIN_TO, mn);
        write_reg(REG_MAX_TO, mx);
        write_reg(REG_LIMIT, 8'(lim));
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        left = n;
        while (left > 0)
        begin
            seq.delete();
            if ($urandom_range(99) < 8)
                seq.push_back(make_event(2'($urandom_range(3)), SAMPLE_W'($urandom)));
            else
            begin
                seq.push_back(make_event(ACT_NEW, SAMPLE_W'($urandom)));
                repeat ($urandom_range(1, 6))
                    seq.push_back(make_event(ACT_SAMPLE, rand_sample_ms()));
                repeat ($urandom_range(0, 7))
                    seq.push_back(make_event(ACT_TIMEOUT, SAMPLE_W'($urandom)));
            end
            foreach (seq[i])
                send_event(seq[i]);
            left -= seq.size();
        end
    endtask

    task automatic test_random_settings();
        run_phase(8'd2, 8'd60, 4'd3, 0, 0, 250);
        run_phase(8'd1, 8'd255, 4'd15, 60, 0, 250);
        run_phase(8'd255, 8'd1, 4'd0, 0, 60, 250);
        run_phase(8'd1, 8'd1, 4'd0, 38, 38, 250);
        run_phase(8'd255, 8'd255, 4'd15, 0, 0, 250);
        run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                  4'($urandom_range(15)), 38, 38, 250);
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        wait_drained();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_span <= 300;
        repeat (20)
            send_event(make_event(ACT_SAMPLE, rand_sample_ms()));
        send_event(make_event(ACT_TIMEOUT, '0));
        wait_drained();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        tx_idle_pct     = 0;
        rx_stall_pct    = 0;
        hold_span       = 0;
        hold_left       = 0;
        hold_taken      = 1'b0;
        mismatches      = 0;
        events_sent     = 0;
        reports_checked = 0;
        give_ups_seen   = 0;
        lim_min     = MIN_TO_RST;
        lim_max     = MAX_TO_RST;
        lim_retx    = LIMIT_RST;
        est_retries = '0;
        reset_estimator();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_event_basics();
        test_clamp_limits();
        test_random_settings();
        test_backpressure();

        wait_drained();
        repeat (4) @(posedge clk);
        $display("tb_top: %0d events sent, %0d results checked (%0d give-ups), %0d mismatches",
                 events_sent, reports_checked, give_ups_seen, mismatches);
        $display("tb_top: covered clamp extremes, inverted range, saturation and stalls");
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
